// File: hw/rtl/cls_pkg.sv
// Package for the compacting list store: sizes, command and status codes,
// and the control bundle broadcast to the row of storage cells.
// Depends on nothing; every other file of the block refers to it.
package cls_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;

    localparam int CMD_BITS  = 3;
    localparam int POS_BITS  = 4;
    localparam int DATA_BITS = 32;
    localparam int LEN_BITS  = 5;
    localparam int STAT_BITS = 2;

    localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int CMP_BITS  = ((CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS) + 1;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [CNT_BITS-1:0]  count_t;
    typedef logic [CMP_BITS-1:0]  cmp_t;
    typedef logic [IDX_BITS-1:0]  idx_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_SET    = 3'd2,
        CMD_GET    = 3'd3,
        CMD_DELETE = 3'd4,
        CMD_QUERY  = 3'd5
    } cmd_t;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Control broadcast to every cell for one accepted command.
    typedef struct packed {
        logic  push_en;
        logic  set_en;
        logic  del_en;
        cmp_t  pos;
        cmp_t  count;
        word_t word;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/cls_cmd_if.sv
// Command channel of the compacting list store: valid, ready and one command beat.
// Depends on cls_pkg for the field widths.
interface cls_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [cls_pkg::CMD_BITS-1:0]  command;
    logic [cls_pkg::POS_BITS-1:0]  position;
    logic [cls_pkg::DATA_BITS-1:0] data_in;

    modport source (output valid, output command, output position, output data_in,
                    input ready);
    modport sink (input valid, input command, input position, input data_in,
                  output ready);
endinterface

// File: hw/rtl/cls_rsp_if.sv
// Result channel of the compacting list store: valid, ready and one result beat.
// Depends on cls_pkg for the field widths.
interface cls_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [cls_pkg::DATA_BITS-1:0] read_word;
    logic [cls_pkg::LEN_BITS-1:0]  length;
    logic                          empty_flag;
    logic [cls_pkg::STAT_BITS-1:0] status;

    modport source (output valid, output read_word, output length, output empty_flag,
                    output status, input ready);
    modport sink (input valid, input read_word, input length, input empty_flag,
                  input status, output ready);
endinterface

// File: hw/rtl/cls_cell.sv
// One storage cell of the list: holds a word and updates it from the command,
// its own position and the word of its upper neighbor. Depends on cls_pkg.
module cls_cell (
    input  logic                clk,
    input  cls_pkg::cell_ctrl_t ctrl,
    input  cls_pkg::idx_t       idx,
    input  cls_pkg::word_t      upper_word,
    output cls_pkg::word_t      word
);

    cls_pkg::word_t word_reg;
    cls_pkg::word_t word_next;
    cls_pkg::cmp_t  my_pos;

    assign my_pos = cls_pkg::CMP_BITS'(idx);

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.push_en && (my_pos == ctrl.count))
        begin
            word_next = ctrl.word;
        end
        else if (ctrl.set_en)
        begin
            if (my_pos == ctrl.pos)
            begin
                word_next = ctrl.word;
            end
            else if ((my_pos >= ctrl.count) && (my_pos < ctrl.pos))
            begin
                word_next = '0;
            end
        end
        else if (ctrl.del_en && (my_pos >= ctrl.pos) && ((my_pos + 1'b1) < ctrl.count))
        begin
            word_next = upper_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// File: hw/rtl/compacting_list_store_unit.sv
// Top level of the compacting list store; depends on cls_pkg, cls_cmd_if,
// cls_rsp_if and cls_cell.
//
// On acceptance of a command beat, the row of cells performs append,
// zero-filled set and the shift-down of delete in the cycle of acceptance, and the
// result beat appears from the output register on the next cycle. A new command is
// taken in every cycle in which the output register is empty or its beat is taken,
// so it sustains one command per cycle while result beats are taken. Storage needs
// no clearing after reset; the block is ready as soon as reset is released.
module compacting_list_store_unit (
    input  logic           clk,
    input  logic           rst_n,
    cls_cmd_if.sink        cmd,
    cls_rsp_if.source      rsp
);

    cls_pkg::word_t      cell_word [cls_pkg::DEPTH];
    cls_pkg::cell_ctrl_t ctrl;

    cls_pkg::count_t     count_reg;
    cls_pkg::count_t     count_next;
    logic                rsp_valid_reg;
    logic [cls_pkg::DATA_BITS-1:0] read_word_reg;
    logic [cls_pkg::DATA_BITS-1:0] read_word_next;
    cls_pkg::status_t    status_reg;
    cls_pkg::status_t    status_next;
    logic [cls_pkg::LEN_BITS-1:0] length_reg;
    logic                empty_reg;

    logic                accept;
    cls_pkg::cmd_t       op;
    cls_pkg::cmp_t       pos_ext;
    cls_pkg::cmp_t       count_ext;
    cls_pkg::cmp_t       depth_ext;
    cls_pkg::count_t     last;
    cls_pkg::idx_t       rd_idx;
    cls_pkg::word_t      rd_word;

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign op        = cls_pkg::cmd_t'(cmd.command);
    assign pos_ext   = cls_pkg::CMP_BITS'(cmd.position);
    assign count_ext = cls_pkg::CMP_BITS'(count_reg);
    assign depth_ext = cls_pkg::CMP_BITS'(cls_pkg::DEPTH);
    assign last      = count_reg - 1'b1;
    assign rd_idx    = (op == cls_pkg::CMD_POP) ? last[cls_pkg::IDX_BITS-1:0]
                                                : pos_ext[cls_pkg::IDX_BITS-1:0];
    assign rd_word   = cell_word[rd_idx];

    always_comb
    begin
        ctrl.push_en   = 1'b0;
        ctrl.set_en    = 1'b0;
        ctrl.del_en    = 1'b0;
        ctrl.pos       = pos_ext;
        ctrl.count     = count_ext;
        ctrl.word      = cls_pkg::WORD_BITS'(cmd.data_in);
        count_next     = count_reg;
        read_word_next = '0;
        status_next    = cls_pkg::ST_OK;
        case (op)
            cls_pkg::CMD_PUSH:
            begin
                if (count_ext >= depth_ext)
                begin
                    status_next = cls_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.push_en = accept;
                    count_next   = count_reg + 1'b1;
                end
            end
            cls_pkg::CMD_POP:
            begin
                if (count_reg == '0)
                begin
                    status_next = cls_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next     = last;
                    read_word_next = cls_pkg::DATA_BITS'(rd_word);
                end
            end
            cls_pkg::CMD_SET:
            begin
                if (pos_ext >= depth_ext)
                begin
                    status_next = cls_pkg::ST_RANGE;
                end
                else
                begin
                    ctrl.set_en = accept;
                    if (pos_ext >= count_ext)
                    begin
                        count_next = cls_pkg::CNT_BITS'(pos_ext + 1'b1);
                    end
                end
            end
            cls_pkg::CMD_GET:
            begin
                if (pos_ext >= count_ext)
                begin
                    status_next = cls_pkg::ST_RANGE;
                end
                else
                begin
                    read_word_next = cls_pkg::DATA_BITS'(rd_word);
                end
            end
            cls_pkg::CMD_DELETE:
            begin
                if (pos_ext >= count_ext)
                begin
                    status_next = cls_pkg::ST_RANGE;
                end
                else
                begin
                    ctrl.del_en = accept;
                    count_next  = last;
                end
            end
            default:
            begin
                status_next = cls_pkg::ST_OK;
            end
        endcase
    end

    for (genvar i = 0; i < cls_pkg::DEPTH; i++)
    begin : g_cell
        cls_pkg::word_t upper;
        if (i < cls_pkg::DEPTH - 1)
        begin : g_mid
            assign upper = cell_word[i + 1];
        end
        else
        begin : g_top
            assign upper = '0;
        end
        cls_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .idx        (cls_pkg::IDX_BITS'(i)),
            .upper_word (upper),
            .word       (cell_word[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_word_reg <= read_word_next;
            status_reg    <= status_next;
            length_reg    <= cls_pkg::LEN_BITS'(count_next);
            empty_reg     <= (count_next == '0);
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_word  = read_word_reg;
    assign rsp.length     = length_reg;
    assign rsp.empty_flag = empty_reg;
    assign rsp.status     = status_reg;

endmodule
